@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the strobe match timer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rsmt_pkg.sv @@
// Types and constants of the rotary strobe match timer.
// No dependencies; used by every module of the block.
package rsmt_pkg;

	localparam int CFG_W    = 9;
	localparam int ANGLE_W  = 10;
	localparam int PERIOD_W = 32;
	localparam int PROD_W   = ANGLE_W + PERIOD_W;
	localparam int FULL_TURN = 360;

	localparam logic [10:0] ANGLE_SHIFT = 11'd7;
	localparam logic [10:0] TURN_ADD    = 11'd360;

	localparam logic [CFG_W-1:0] LED_ANGLE_RST   = 9'd180;
	localparam logic [CFG_W-1:0] START_ANGLE_RST = 9'd67;
	localparam logic [CFG_W-1:0] END_ANGLE_RST   = 9'd68;

	typedef enum logic [1:0] {
		CFG_LED_ANGLE   = 2'd0,
		CFG_START_ANGLE = 2'd1,
		CFG_END_ANGLE   = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_REV  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic tick;
		logic rev;
	} match_ctl_t;

endpackage

@@ rtl/rotary_strobe_match_timer.sv @@
// Top level of the rotary strobe match timer: ports, input and result registers, config.
// Depends on rsmt_pkg, rsmt_angle_time, rsmt_match and assert_macros.svh.
//
// channel  direction  handshake                fields
// s_*      in         s_tvalid / s_tready      tuser: command; tdata: rev_period
// m_*      out        m_tvalid / m_tready      tdata: led_level, match_hit
// cfg_*    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One transaction per cycle unless the result stalls; each result passes the input register, then the result register.
// The revolution multiply and the tick compare both sit in the cycle after the input register.
// Reset gives LED off, next-tick counter one, match all ones and default angles.
// A stalled result holds the input register; cfg_ready is always high.
`include "assert_macros.svh"

module rotary_strobe_match_timer #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rsmt_pkg::PERIOD_W-1:0]  s_tdata,   // [31:0] rev_period
	input  logic                           s_tuser,   // [0] command
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [0] led_level, [1] match_hit
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [rsmt_pkg::CFG_W-1:0]     cfg_data
);

	logic [rsmt_pkg::CFG_W-1:0] led_angle_q;
	logic [rsmt_pkg::CFG_W-1:0] start_angle_q;
	logic [rsmt_pkg::CFG_W-1:0] end_angle_q;

	logic                          valid_s1;
	rsmt_pkg::cmd_t                cmd_s1;
	logic [rsmt_pkg::PERIOD_W-1:0] period_s1;

	logic m_valid_q;
	logic led_q;
	logic hit_q;

	logic                        adv;
	rsmt_pkg::match_ctl_t        ctl;
	logic [rsmt_pkg::PROD_W-1:0] on_time;
	logic [rsmt_pkg::PROD_W-1:0] off_time;
	logic                        hit;
	logic                        led_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_angle_q <= rsmt_pkg::LED_ANGLE_RST;
			start_angle_q <= rsmt_pkg::START_ANGLE_RST;
			end_angle_q <= rsmt_pkg::END_ANGLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rsmt_pkg::CFG_LED_ANGLE:   led_angle_q <= cfg_data;
				rsmt_pkg::CFG_START_ANGLE: start_angle_q <= cfg_data;
				rsmt_pkg::CFG_END_ANGLE:   end_angle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= rsmt_pkg::cmd_t'(s_tuser);
			period_s1 <= s_tdata;
		end
	end

	always_comb begin
		ctl.tick = adv && (cmd_s1 == rsmt_pkg::CMD_TICK);
		ctl.rev = adv && (cmd_s1 == rsmt_pkg::CMD_REV) && (period_s1 != '0);
	end

	rsmt_angle_time u_on_time (
		.led_angle   (led_angle_q),
		.edge_angle  (end_angle_q),
		.period      (period_s1),
		.scaled_time (on_time)
	);

	rsmt_angle_time u_off_time (
		.led_angle   (led_angle_q),
		.edge_angle  (start_angle_q),
		.period      (period_s1),
		.scaled_time (off_time)
	);

	rsmt_match #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.on_time  (on_time),
		.off_time (off_time),
		.hit      (hit),
		.led_next (led_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q <= 1'b0;
			hit_q <= 1'b0;
		end else if (adv) begin
			led_q <= led_next;
			hit_q <= hit;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {6'b000000, hit_q, led_q};

	`ASSERT_SAME(a_hit_on_tick, clk, arst_n, hit, ctl.tick, "match hit without a tick")
	`ASSERT_NEXT(a_rev_no_hit, clk, arst_n, adv && (cmd_s1 == rsmt_pkg::CMD_REV),
		m_tvalid && !m_tdata[1], "revolution result shows a match hit")
	`ASSERT_SAME(a_stall_blocks, clk, arst_n, valid_s1 && m_valid_q && !m_tready,
		!s_tready && !adv, "input taken while result is stalled")
	`ASSERT_NEXT(a_led_steady, clk, arst_n, adv && !hit,
		m_tdata[0] == $past(led_q), "led level changed without a hit")

endmodule

@@ rtl/rsmt_angle_time.sv @@
// Scaled edge time: wrapped angle times period, kept as 360 times the tick count.
// Depends on rsmt_pkg.
module rsmt_angle_time (
	input  logic [rsmt_pkg::CFG_W-1:0]    led_angle,
	input  logic [rsmt_pkg::CFG_W-1:0]    edge_angle,
	input  logic [rsmt_pkg::PERIOD_W-1:0] period,
	output logic [rsmt_pkg::PROD_W-1:0]   scaled_time
);

	logic signed [10:0] angle_raw;
	logic signed [10:0] angle_wrap;
	logic [rsmt_pkg::ANGLE_W-1:0] angle_u;

	always_comb begin
		angle_raw = $signed({2'b00, led_angle}) - $signed({2'b00, edge_angle})
			+ $signed(rsmt_pkg::ANGLE_SHIFT);
		angle_wrap = angle_raw[10] ? (angle_raw + $signed(rsmt_pkg::TURN_ADD)) : angle_raw;
		angle_u = angle_wrap[10] ? '0 : angle_wrap[rsmt_pkg::ANGLE_W-1:0];
		scaled_time = rsmt_pkg::PROD_W'(angle_u) * rsmt_pkg::PROD_W'(period);
	end

endmodule

@@ rtl/rsmt_match.sv @@
// Tick counter, stored edge times, armed match and LED level.
// Depends on rsmt_pkg; counts in ticks and in steps of 360 side by side.
module rsmt_match #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rsmt_pkg::match_ctl_t         ctl,
	input  logic [rsmt_pkg::PROD_W-1:0]  on_time,
	input  logic [rsmt_pkg::PROD_W-1:0]  off_time,
	output logic                         hit,
	output logic                         led_next
);

	localparam int SCL_W = COUNT_WIDTH + 9;
	localparam int DW = ((rsmt_pkg::PROD_W > SCL_W) ? rsmt_pkg::PROD_W : SCL_W) + 1;
	localparam logic [DW-1:0] TURN_D = DW'(rsmt_pkg::FULL_TURN);
	localparam logic [DW-1:0] SAT_D = TURN_D << COUNT_WIDTH;
	localparam logic [SCL_W-1:0] TURN_S = SCL_W'(rsmt_pkg::FULL_TURN);
	localparam logic [1:0] SLOT_DONE = 2'd2;
	localparam logic [1:0] SLOT_OFF = 2'd1;

	logic [COUNT_WIDTH-1:0]      tick_next_q;
	logic [SCL_W-1:0]            scaled_q;
	logic [rsmt_pkg::PROD_W-1:0] times_q [2];
	logic [rsmt_pkg::PROD_W-1:0] armed_q;
	logic                        ones_q;
	logic [1:0]                  slot_q;
	logic                        led_q;

	logic [DW-1:0] diff;
	logic          in_win;
	logic          use_ones;

	always_comb begin
		diff = DW'(armed_q) - DW'(scaled_q);
		in_win = !diff[DW-1] && (diff < TURN_D);
		use_ones = ones_q || (DW'(armed_q) >= SAT_D);
		hit = ctl.tick && (use_ones ? (tick_next_q == '1) : in_win);
		led_next = led_q ^ hit;
	end

	always_ff @(posedge clk) begin
		if (ctl.rev) begin
			times_q[0] <= on_time;
			times_q[1] <= off_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_next_q <= COUNT_WIDTH'(1);
			scaled_q <= TURN_S;
			armed_q <= '0;
			ones_q <= 1'b1;
			slot_q <= '0;
			led_q <= 1'b0;
		end else if (ctl.rev) begin
			tick_next_q <= COUNT_WIDTH'(1);
			scaled_q <= TURN_S;
			armed_q <= on_time;
			ones_q <= 1'b0;
			slot_q <= SLOT_OFF;
		end else if (ctl.tick) begin
			tick_next_q <= tick_next_q + COUNT_WIDTH'(1);
			scaled_q <= (tick_next_q == '1) ? '0 : (scaled_q + TURN_S);
			led_q <= led_next;
			if (hit) begin
				if (slot_q == SLOT_DONE) begin
					ones_q <= 1'b1;
				end else begin
					armed_q <= times_q[slot_q[0]];
					ones_q <= 1'b0;
					slot_q <= slot_q + 2'd1;
				end
			end
		end
	end

endmodule
